// File: rtl/twd_pkg.sv
package twd_pkg;

	localparam int KIND_W    = 2;
	localparam int IDX_W     = 4;
	localparam int RAW_W     = 16;
	localparam int VK_W      = 2;
	localparam int VAL_W     = 25;
	localparam int REF_W     = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [7:0] SYNC_SWEEP = 8'hAA;
	localparam logic [7:0] SYNC_PMT   = 8'hBB;
	localparam logic [7:0] SYNC_HK    = 8'hCC;

	localparam logic [KIND_W-1:0] KIND_SWEEP = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PMT   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_HK    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_REF_WIDE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REF_NARROW = 2'd1;

	localparam logic [REF_W-1:0] REF_WIDE_RST   = 4'd5;
	localparam logic [REF_W-1:0] REF_NARROW_RST = 4'd3;

	localparam logic signed [VAL_W-1:0] SCALED_MAX = 25'sd15000000;
	localparam logic signed [VAL_W-1:0] SCALED_MIN = -25'sd8000000;

	typedef enum logic [VK_W-1:0] {
		VK_SYNC = 2'd0,
		VK_SEQ  = 2'd1,
		VK_UV   = 2'd2,
		VK_MDEG = 2'd3
	} value_kind_t;

	typedef enum logic [1:0] {
		CONV_RAW    = 2'd0,
		CONV_WIDE   = 2'd1,
		CONV_NARROW = 2'd2,
		CONV_MDEG   = 2'd3
	} conv_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [IDX_W-1:0]  idx;
		logic [RAW_W-1:0]  raw;
		value_kind_t       vk;
		conv_t             conv;
	} word_t;

	function automatic logic [IDX_W-1:0] field_count(input logic [KIND_W-1:0] kind);
		logic [IDX_W-1:0] n;
		unique case (kind)
			KIND_SWEEP: n = 4'd8;
			KIND_PMT:   n = 4'd3;
			KIND_HK:    n = 4'd13;
			default:    n = 4'd13;
		endcase
		return n;
	endfunction

endpackage

// File: rtl/twd_front.sv
module twd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 acc,
	input  logic [7:0]           rx_byte,
	output logic                 push,
	output twd_pkg::word_t       word
);
	import twd_pkg::*;

	localparam logic [1:0] ACT_NONE = 2'd0;

	logic [7:0]       prev_q;
	logic [1:0]       active_q;
	logic             phase_q [3];
	logic [IDX_W-1:0] cnt_q [3];

	logic             sync;
	logic [1:0]       sk;
	logic [1:0]       act_n;
	logic [1:0]       k;
	logic             phase_n [3];
	logic [IDX_W-1:0] cnt_n [3];
	logic [IDX_W-1:0] lim;
	logic [IDX_W-1:0] idx;
	logic             emit;

	always_comb begin
		priority if (rx_byte == SYNC_SWEEP) begin
			sk = KIND_SWEEP;
		end else if (rx_byte == SYNC_PMT) begin
			sk = KIND_PMT;
		end else begin
			sk = KIND_HK;
		end
		sync = (prev_q == rx_byte) &&
			(rx_byte == SYNC_SWEEP || rx_byte == SYNC_PMT || rx_byte == SYNC_HK);
	end

	always_comb begin
		phase_n = phase_q;
		cnt_n   = cnt_q;
		act_n   = active_q;
		emit    = 1'b0;
		idx     = '0;
		if (sync) begin
			phase_n[sk] = 1'b1;
			cnt_n[sk]   = '0;
			act_n       = sk + 2'd1;
		end
		k   = act_n - 2'd1;
		lim = field_count(k);
		if (act_n != ACT_NONE) begin
			if (!phase_n[k]) begin
				phase_n[k] = 1'b1;
			end else begin
				phase_n[k] = 1'b0;
				idx        = (cnt_n[k] >= lim) ? '0 : cnt_n[k];
				cnt_n[k]   = (idx == lim - 4'd1) ? '0 : idx + 4'd1;
				emit       = 1'b1;
			end
		end
	end

	always_comb begin
		word.kind = k;
		word.idx  = idx;
		word.raw  = {prev_q, rx_byte};
		priority if (idx == 4'd0) begin
			word.vk   = VK_SYNC;
			word.conv = CONV_RAW;
		end else if (idx == 4'd1) begin
			word.vk   = VK_SEQ;
			word.conv = CONV_RAW;
		end else begin
			unique case (k)
				KIND_SWEEP: begin
					priority if (idx == 4'd2) begin
						word.vk   = VK_UV;
						word.conv = CONV_WIDE;
					end else if (idx <= 4'd4) begin
						word.vk   = VK_UV;
						word.conv = CONV_NARROW;
					end else begin
						word.vk   = VK_MDEG;
						word.conv = CONV_MDEG;
					end
				end
				KIND_PMT: begin
					word.vk   = VK_UV;
					word.conv = CONV_WIDE;
				end
				KIND_HK: begin
					word.vk   = VK_UV;
					word.conv = CONV_NARROW;
				end
				default: begin
					word.vk   = VK_UV;
					word.conv = CONV_NARROW;
				end
			endcase
		end
	end

	assign push = acc && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= '0;
			active_q <= ACT_NONE;
			for (int i = 0; i < 3; i++) begin
				phase_q[i] <= 1'b0;
				cnt_q[i]   <= '0;
			end
		end else if (acc) begin
			prev_q   <= rx_byte;
			active_q <= act_n;
			phase_q  <= phase_n;
			cnt_q    <= cnt_n;
		end
	end

endmodule

// File: rtl/twd_queue.sv
module twd_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  twd_pkg::word_t push_data,
	output logic           full,
	input  logic           pop,
	output twd_pkg::word_t pop_data,
	output logic           empty
);
	import twd_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	word_t            mem_q [DEPTH];

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

// File: rtl/twd_back.sv
module twd_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_empty,
	input  twd_pkg::word_t                   q_data,
	output logic                             pop,
	input  logic [twd_pkg::REF_W-1:0]        ref_wide,
	input  logic [twd_pkg::REF_W-1:0]        ref_narrow,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [twd_pkg::KIND_W-1:0]       packet_kind,
	output logic [twd_pkg::IDX_W-1:0]        field_index,
	output logic [twd_pkg::RAW_W-1:0]        raw_word,
	output logic [twd_pkg::VK_W-1:0]         value_kind,
	output logic signed [twd_pkg::VAL_W-1:0] scaled_value
);
	import twd_pkg::*;

	function automatic logic [14:0] div_of(input conv_t c);
		logic [14:0] d;
		unique case (c)
			CONV_WIDE: d = 15'd13107;
			CONV_MDEG: d = 15'd7371;
			default:   d = 15'd819;
		endcase
		return d;
	endfunction

	function automatic logic [22:0] recip_of(input conv_t c);
		logic [22:0] m;
		unique case (c)
			CONV_WIDE: m = 23'd327685;
			CONV_MDEG: m = 23'd582684;
			default:   m = 23'd5244160;
		endcase
		return m;
	endfunction

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	word_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6;

	logic [19:0] p_s1;
	logic [31:0] y_s2, y_s3;
	logic [29:0] base_s2, base_s3, base_s4;
	logic [22:0] qe_s3, qe_s4;
	logic [14:0] r0_s4;
	logic [29:0] sum_s5;
	logic        rnz_s5;
	logic signed [VAL_W-1:0] val_s6;

	logic [REF_W-1:0] ref_sel;
	logic [19:0]      p_n;
	logic [31:0]      y_n;
	logic [29:0]      base_n;
	logic [54:0]      prod_n;
	logic [31:0]      qc_n;
	logic             corr_n;
	logic [22:0]      q_n;
	logic [14:0]      r_n;
	logic [29:0]      sum_n;
	logic [29:0]      fin_n;
	logic signed [VAL_W-1:0] val_n;

	assign adv = !v_s6 || !out_stall;
	assign pop = adv && !q_empty;

	always_comb begin
		ref_sel = (q_data.conv == CONV_WIDE) ? ref_wide : ref_narrow;
		p_n     = 20'(q_data.raw) * 20'(ref_sel);
	end

	always_comb begin
		unique case (tag_s1.conv)
			CONV_WIDE: begin
				y_n    = 32'(p_s1) * 32'd3395;
				base_n = 30'(p_s1) * 30'd15;
			end
			CONV_NARROW: begin
				y_n    = 32'(p_s1) * 32'd164;
				base_n = 30'(p_s1) * 30'd244;
			end
			CONV_MDEG: begin
				y_n    = 32'(p_s1) * 32'd1966 + 32'd5733;
				base_n = 30'd452223 - 30'(p_s1) * 30'd54;
			end
			default: begin
				y_n    = '0;
				base_n = '0;
			end
		endcase
	end

	assign prod_n = 55'(y_s2) * 55'(recip_of(tag_s2.conv));
	assign qc_n   = 32'(qe_s3) * 32'(div_of(tag_s3.conv));

	always_comb begin
		corr_n = (r0_s4 >= div_of(tag_s4.conv));
		q_n    = qe_s4 + 23'(corr_n);
		r_n    = corr_n ? r0_s4 - div_of(tag_s4.conv) : r0_s4;
		sum_n  = (tag_s4.conv == CONV_MDEG) ? base_s4 - 30'(q_n) : base_s4 + 30'(q_n);
	end

	always_comb begin
		fin_n = sum_s5;
		if (tag_s5.conv == CONV_MDEG && rnz_s5 && signed'(sum_s5) > 30'sd0) begin
			fin_n = sum_s5 - 30'd1;
		end
		priority if (tag_s5.conv == CONV_RAW) begin
			val_n = signed'(VAL_W'(tag_s5.raw));
		end else if (signed'(fin_n) > SCALED_MAX) begin
			val_n = SCALED_MAX;
		end else if (signed'(fin_n) < SCALED_MIN) begin
			val_n = SCALED_MIN;
		end else begin
			val_n = signed'(fin_n[VAL_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= !q_empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1  <= q_data;
			p_s1    <= p_n;
			tag_s2  <= tag_s1;
			y_s2    <= y_n;
			base_s2 <= base_n;
			tag_s3  <= tag_s2;
			y_s3    <= y_s2;
			base_s3 <= base_s2;
			qe_s3   <= prod_n[54:32];
			tag_s4  <= tag_s3;
			base_s4 <= base_s3;
			qe_s4   <= qe_s3;
			r0_s4   <= 15'(y_s3 - qc_n);
			tag_s5  <= tag_s4;
			sum_s5  <= sum_n;
			rnz_s5  <= (r_n != '0);
			tag_s6  <= tag_s5;
			val_s6  <= val_n;
		end
	end

	assign out_valid    = v_s6;
	assign packet_kind  = tag_s6.kind;
	assign field_index  = tag_s6.idx;
	assign raw_word     = tag_s6.raw;
	assign value_kind   = tag_s6.vk;
	assign scaled_value = val_s6;

endmodule

// File: rtl/telemetry_word_deframer.sv
// Throughput: one byte accepted per cycle while in_stall is low; the converter
// returns one word per cycle while a word is queued and out_stall is low. Each word
// passes the six-stage divide-by-constant conversion pipeline behind the word queue.
// in_stall rises only when the word queue is full.
// Reset: arst_n clears deframing state, queue and pipeline at once; the reference
// registers return to 5 and 3. No clearing pass follows reset.
module telemetry_word_deframer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [7:0]                           rx_byte,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [twd_pkg::KIND_W-1:0]           packet_kind,
	output logic [twd_pkg::IDX_W-1:0]            field_index,
	output logic [twd_pkg::RAW_W-1:0]            raw_word,
	output logic [twd_pkg::VK_W-1:0]             value_kind,
	output logic signed [twd_pkg::VAL_W-1:0]     scaled_value,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [twd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [twd_pkg::REF_W-1:0]            cfg_data
);
	import twd_pkg::*;

	logic             acc;
	logic             push;
	logic             full;
	logic             pop;
	logic             empty;
	word_t            push_data;
	word_t            pop_data;
	logic [REF_W-1:0] ref_wide_q;
	logic [REF_W-1:0] ref_narrow_q;

	assign cfg_ready = 1'b1;
	assign in_stall  = full;
	assign acc       = in_valid && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_wide_q   <= REF_WIDE_RST;
			ref_narrow_q <= REF_NARROW_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_REF_WIDE:   ref_wide_q   <= cfg_data;
				REG_REF_NARROW: ref_narrow_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	twd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc),
		.rx_byte (rx_byte),
		.push    (push),
		.word    (push_data)
	);

	twd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	twd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (empty),
		.q_data       (pop_data),
		.pop          (pop),
		.ref_wide     (ref_wide_q),
		.ref_narrow   (ref_narrow_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.packet_kind  (packet_kind),
		.field_index  (field_index),
		.raw_word     (raw_word),
		.value_kind   (value_kind),
		.scaled_value (scaled_value)
	);

endmodule

// File: rtl/twd_checker.sv
module twd_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [twd_pkg::KIND_W-1:0]       packet_kind,
	input logic [twd_pkg::IDX_W-1:0]        field_index,
	input logic [twd_pkg::RAW_W-1:0]        raw_word,
	input logic [twd_pkg::VK_W-1:0]         value_kind,
	input logic signed [twd_pkg::VAL_W-1:0] scaled_value
);
	import twd_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(raw_word) && $stable(scaled_value))
		else $error("stalled word changed");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> field_index < field_count(packet_kind))
		else $error("field index past packet length");

	a_sync_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && field_index == 4'd0 |-> value_kind == VK_SYNC)
		else $error("field zero is not tagged as sync id");

	a_raw_pass: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (value_kind == VK_SYNC || value_kind == VK_SEQ) |->
		scaled_value == signed'({9'd0, raw_word}))
		else $error("raw field value differs from word");

	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> scaled_value <= SCALED_MAX && scaled_value >= SCALED_MIN)
		else $error("scaled value out of range");

endmodule

bind telemetry_word_deframer twd_checker u_twd_checker (.*);

// File: test/telemetry_word_deframer_tb.sv
module telemetry_word_deframer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import twd_pkg::*;

	localparam longint FULL_WIDE   = 65535;
	localparam longint FULL_NARROW = 4095;
	localparam longint OFFSET_MV   = 2035;
	localparam int     PHASE_BYTES = 122;
	localparam int     N_SCRIPT    = 27;
	localparam int     SETTLE      = 12;

	typedef struct {
		logic [KIND_W-1:0]       kind;
		logic [IDX_W-1:0]        idx;
		logic [RAW_W-1:0]        raw;
		value_kind_t             vk;
		logic signed [VAL_W-1:0] val;
	} word_exp_t;

	typedef struct {
		logic [7:0]              b;
		bit                      typed;
		bit                      has_word;
		logic [KIND_W-1:0]       kind;
		logic [IDX_W-1:0]        idx;
		logic [RAW_W-1:0]        raw;
		value_kind_t             vk;
		logic signed [VAL_W-1:0] val;
	} script_row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic [7:0]              rx_byte;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [KIND_W-1:0]       packet_kind;
	logic [IDX_W-1:0]        field_index;
	logic [RAW_W-1:0]        raw_word;
	logic [VK_W-1:0]         value_kind;
	logic signed [VAL_W-1:0] scaled_value;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [REF_W-1:0]        cfg_data;

	word_exp_t   pending_words[$];
	int          mismatches = 0;
	int          bytes_sent;
	int          stall_left = 0;
	bit          idle_on;

	logic [7:0]       last_byte;
	bit               in_packet;
	logic [KIND_W-1:0] cur_kind;
	bit               half_word[3];
	logic [IDX_W-1:0] field_pos[3];
	logic [REF_W-1:0] ref_wide;
	logic [REF_W-1:0] ref_narrow;

	script_row_t script [N_SCRIPT] = '{
		'{8'hAA, 1'b1, 1'b0, KIND_SWEEP, 4'd0, 16'h0000, VK_SYNC, 25'sd0},
		'{8'hAA, 1'b1, 1'b1, KIND_SWEEP, 4'd0, 16'hAAAA, VK_SYNC, 25'sd43690},
		'{8'h00, 1'b1, 1'b0, KIND_SWEEP, 4'd0, 16'h0000, VK_SYNC, 25'sd0},
		'{8'h07, 1'b1, 1'b1, KIND_SWEEP, 4'd1, 16'h0007, VK_SEQ, 25'sd7},
		'{8'hFF, 1'b1, 1'b0, KIND_SWEEP, 4'd0, 16'h0000, VK_SYNC, 25'sd0},
		'{8'hFF, 1'b1, 1'b1, KIND_SWEEP, 4'd2, 16'hFFFF, VK_UV, 25'sd5000000},
		'{8'h00, 1'b1, 1'b0, KIND_SWEEP, 4'd0, 16'h0000, VK_SYNC, 25'sd0},
		'{8'h00, 1'b1, 1'b1, KIND_SWEEP, 4'd3, 16'h0000, VK_UV, 25'sd0},
		'{8'hFF, 1'b1, 1'b0, KIND_SWEEP, 4'd0, 16'h0000, VK_SYNC, 25'sd0},
		'{8'hFF, 1'b1, 1'b1, KIND_SWEEP, 4'd4, 16'hFFFF, VK_UV, 25'sd15000000},
		'{8'h00, 1'b1, 1'b0, KIND_SWEEP, 4'd0, 16'h0000, VK_SYNC, 25'sd0},
		'{8'h00, 1'b1, 1'b1, KIND_SWEEP, 4'd5, 16'h0000, VK_MDEG, 25'sd452222},
		'{8'hFF, 1'b1, 1'b0, KIND_SWEEP, 4'd0, 16'h0000, VK_SYNC, 25'sd0},
		'{8'hFF, 1'b1, 1'b1, KIND_SWEEP, 4'd6, 16'hFFFF, VK_MDEG, -25'sd8000000},
		'{8'h80, 1'b0, 1'b0, KIND_SWEEP, 4'd0, 16'h0000, VK_SYNC, 25'sd0},
		'{8'h00, 1'b0, 1'b0, KIND_SWEEP, 4'd0, 16'h0000, VK_SYNC, 25'sd0},
		'{8'h12, 1'b1, 1'b0, KIND_SWEEP, 4'd0, 16'h0000, VK_SYNC, 25'sd0},
		'{8'h34, 1'b1, 1'b1, KIND_SWEEP, 4'd0, 16'h1234, VK_SYNC, 25'sd4660},
		'{8'hBB, 1'b1, 1'b0, KIND_SWEEP, 4'd0, 16'h0000, VK_SYNC, 25'sd0},
		'{8'hBB, 1'b1, 1'b1, KIND_PMT, 4'd0, 16'hBBBB, VK_SYNC, 25'sd48059},
		'{8'hFF, 1'b1, 1'b0, KIND_SWEEP, 4'd0, 16'h0000, VK_SYNC, 25'sd0},
		'{8'hFF, 1'b1, 1'b1, KIND_PMT, 4'd1, 16'hFFFF, VK_SEQ, 25'sd65535},
		'{8'hCC, 1'b1, 1'b0, KIND_SWEEP, 4'd0, 16'h0000, VK_SYNC, 25'sd0},
		'{8'hCC, 1'b1, 1'b1, KIND_HK, 4'd0, 16'hCCCC, VK_SYNC, 25'sd52428},
		'{8'hCC, 1'b1, 1'b1, KIND_HK, 4'd0, 16'hCCCC, VK_SYNC, 25'sd52428},
		'{8'hAA, 1'b1, 1'b0, KIND_SWEEP, 4'd0, 16'h0000, VK_SYNC, 25'sd0},
		'{8'hAA, 1'b1, 1'b1, KIND_SWEEP, 4'd0, 16'hAAAA, VK_SYNC, 25'sd43690}
	};

	telemetry_word_deframer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.packet_kind  (packet_kind),
		.field_index  (field_index),
		.raw_word     (raw_word),
		.value_kind   (value_kind),
		.scaled_value (scaled_value),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic longint clip_scaled(input longint v);
		if (v > longint'(SCALED_MAX)) begin
			return longint'(SCALED_MAX);
		end
		if (v < longint'(SCALED_MIN)) begin
			return longint'(SCALED_MIN);
		end
		return v;
	endfunction

	function automatic longint microvolts(input logic [RAW_W-1:0] raw,
			input logic [REF_W-1:0] vref, input longint full);
		return clip_scaled(longint'(raw) * longint'(vref) * 64'sd1000000 / full);
	endfunction

	function automatic longint millidegrees(input logic [RAW_W-1:0] raw,
			input logic [REF_W-1:0] vref);
		longint num;
		num = (OFFSET_MV * FULL_NARROW - longint'(raw) * longint'(vref) * 64'sd1000) * 64'sd2000;
		return clip_scaled(num / (64'sd9 * FULL_NARROW));
	endfunction

	function automatic logic [IDX_W-1:0] fields_in(input logic [KIND_W-1:0] kind);
		case (kind)
			KIND_SWEEP: return 4'd8;
			KIND_PMT:   return 4'd3;
			default:    return 4'd13;
		endcase
	endfunction

	function automatic bit deframe_byte(input logic [7:0] b, output word_exp_t w);
		logic [RAW_W-1:0] raw;
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] n;
		int               k;
		longint           v;
		raw = {last_byte, b};
		if (last_byte == b && (b == SYNC_SWEEP || b == SYNC_PMT || b == SYNC_HK)) begin
			cur_kind = (b == SYNC_SWEEP) ? KIND_SWEEP : (b == SYNC_PMT) ? KIND_PMT : KIND_HK;
			half_word[cur_kind] = 1'b1;
			field_pos[cur_kind] = '0;
			in_packet = 1'b1;
		end
		last_byte = b;
		if (!in_packet) begin
			return 1'b0;
		end
		k = cur_kind;
		if (!half_word[k]) begin
			half_word[k] = 1'b1;
			return 1'b0;
		end
		half_word[k] = 1'b0;
		n = fields_in(cur_kind);
		idx = (field_pos[k] >= n) ? 4'd0 : field_pos[k];
		field_pos[k] = (idx == n - 4'd1) ? 4'd0 : idx + 4'd1;
		w.kind = cur_kind;
		w.idx = idx;
		w.raw = raw;
		if (idx == 4'd0) begin
			w.vk = VK_SYNC;
			v = longint'(raw);
		end else if (idx == 4'd1) begin
			w.vk = VK_SEQ;
			v = longint'(raw);
		end else if (cur_kind == KIND_SWEEP) begin
			if (idx == 4'd2) begin
				w.vk = VK_UV;
				v = microvolts(raw, ref_wide, FULL_WIDE);
			end else if (idx <= 4'd4) begin
				w.vk = VK_UV;
				v = microvolts(raw, ref_narrow, FULL_NARROW);
			end else begin
				w.vk = VK_MDEG;
				v = millidegrees(raw, ref_narrow);
			end
		end else if (cur_kind == KIND_PMT) begin
			w.vk = VK_UV;
			v = microvolts(raw, ref_wide, FULL_WIDE);
		end else begin
			w.vk = VK_UV;
			v = microvolts(raw, ref_narrow, FULL_NARROW);
		end
		w.val = v[VAL_W-1:0];
		return 1'b1;
	endfunction

	task automatic put_byte(input logic [7:0] b);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 14);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
	endtask

	task automatic feed_byte(input logic [7:0] b);
		word_exp_t w;
		put_byte(b);
		if (deframe_byte(b, w)) begin
			pending_words.push_back(w);
		end
	endtask

	task automatic feed_word(input logic [RAW_W-1:0] word);
		feed_byte(word[15:8]);
		feed_byte(word[7:0]);
	endtask

	task automatic drain_words();
		in_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_refs(input logic [REF_W-1:0] wide, input logic [REF_W-1:0] narrow);
		cfg_valid <= 1'b1;
		cfg_index <= REG_REF_WIDE;
		cfg_data <= wide;
		do @(posedge clk); while (!cfg_ready);
		ref_wide = wide;
		cfg_index <= REG_REF_NARROW;
		cfg_data <= narrow;
		do @(posedge clk); while (!cfg_ready);
		ref_narrow = narrow;
		cfg_valid <= 1'b0;
	endtask

	task automatic random_packet(input bit last_phase);
		logic [7:0]       sync;
		logic [RAW_W-1:0] word;
		int               nwords;
		int               nnoise;
		int               sel;
		if (!last_phase && $urandom_range(0, 4) == 0) begin
			idle_on = !idle_on;
		end
		sel = $urandom_range(0, 2);
		sync = (sel == 0) ? SYNC_SWEEP : (sel == 1) ? SYNC_PMT : SYNC_HK;
		if ($urandom_range(0, 99) < 80) begin
			feed_byte(sync);
			feed_byte(sync);
			nwords = $urandom_range(0, 2 * fields_in(sel[KIND_W-1:0]) + 2);
			for (int i = 0; i < nwords; i++) begin
				case ($urandom_range(0, 7))
					0:       word = 16'h0000;
					1:       word = 16'hFFFF;
					default: word = 16'($urandom_range(0, 65535));
				endcase
				feed_word(word);
				if ($urandom_range(0, 19) == 0) begin
					feed_byte(8'($urandom_range(0, 255)));
				end
			end
		end else begin
			nnoise = $urandom_range(1, 6);
			for (int i = 0; i < nnoise; i++) begin
				feed_byte(($urandom_range(0, 3) == 0) ? sync : 8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic note_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%t %s", $realtime, what);
		end
	endtask

	always @(posedge clk) begin : word_check
		word_exp_t e;
		if (out_valid && !out_stall) begin
			if (pending_words.size() == 0) begin
				note_mismatch($sformatf("unexpected word: kind %0d idx %0d raw %h vk %0d val %0d",
					packet_kind, field_index, raw_word, value_kind, scaled_value));
			end else begin
				e = pending_words.pop_front();
				if (packet_kind !== e.kind || field_index !== e.idx || raw_word !== e.raw ||
						value_kind !== e.vk || scaled_value !== e.val) begin
					note_mismatch($sformatf({"word mismatch: exp kind %0d idx %0d raw %h vk %0d ",
						"val %0d, got kind %0d idx %0d raw %h vk %0d val %0d"},
						e.kind, e.idx, e.raw, e.vk, e.val,
						packet_kind, field_index, raw_word, value_kind, scaled_value));
				end
			end
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 13);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	initial begin
		#2_000_000;
		$display("[telemetry_word_deframer] ERROR");
		$finish;
	end

	initial begin
		word_exp_t w;
		int        phase_end;
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		bytes_sent = 0;
		idle_on = 1'b1;
		last_byte = '0;
		in_packet = 1'b0;
		cur_kind = KIND_SWEEP;
		for (int k = 0; k < 3; k++) begin
			half_word[k] = 1'b0;
			field_pos[k] = '0;
		end
		ref_wide = REF_WIDE_RST;
		ref_narrow = REF_NARROW_RST;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_SCRIPT; i++) begin
			put_byte(script[i].b);
			if (deframe_byte(script[i].b, w) && !script[i].typed) begin
				pending_words.push_back(w);
			end
			if (script[i].typed && script[i].has_word) begin
				w.kind = script[i].kind;
				w.idx = script[i].idx;
				w.raw = script[i].raw;
				w.vk = script[i].vk;
				w.val = script[i].val;
				pending_words.push_back(w);
			end
		end

		for (int p = 0; p < 6; p++) begin
			drain_words();
			case (p)
				0: set_refs(4'd15, 4'd15);
				1: set_refs(4'd1, 4'd1);
				2: set_refs(4'd0, 4'd0);
				3: set_refs(4'd15, 4'd1);
				4: set_refs(4'd1, 4'd15);
				default: set_refs(4'($urandom_range(1, 15)), 4'($urandom_range(1, 15)));
			endcase
			if (p == 5) begin
				idle_on = 1'b0;
			end
			phase_end = bytes_sent + PHASE_BYTES;
			while (bytes_sent < phase_end) begin
				random_packet(p == 5);
			end
		end

		in_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("[telemetry_word_deframer] OK");
		end else begin
			$display("[telemetry_word_deframer] ERROR");
		end
		$finish;
	end

endmodule
